@@ rtl/access_stride_monitor_top_macros.svh @@
// ----------------------------------------------------------------------------
// access_stride_monitor_top_macros
// Assertion macros used by asm_back in the stride monitor RTL.
// ----------------------------------------------------------------------------
`ifndef ACCESS_STRIDE_MONITOR_TOP_MACROS_SVH
`define ACCESS_STRIDE_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("access_stride_monitor: check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define ASM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("access_stride_monitor: check failed");

`endif

@@ rtl/asm_pkg.sv @@
// ----------------------------------------------------------------------------
// asm_pkg
// Types and constants for the access stride monitor.
// ----------------------------------------------------------------------------
package asm_pkg;

  localparam int unsigned LOG_CAPACITY = 1048576;
  localparam int ENTRY_W = $clog2(LOG_CAPACITY + 1);

  localparam int CNT_W = 20;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int SHIFT_W = 6;
  localparam logic [SHIFT_W-1:0] LINE_SHIFT_RST = 6'd7;

  localparam logic signed [31:0] STRIDE_MIN_RST = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] STRIDE_MAX_RST = 32'sh8000_0000;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    OP_RECORD,
    OP_DROP,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic        kind;
    logic        is_write;
    logic [63:0] address;
    logic [11:0] access_size;
  } in_item_t;

  typedef struct packed {
    logic                    accepted;
    logic signed [31:0]      stride;
    logic                    stride_valid;
    logic                    line_changed;
    logic [CNT_W-1:0]        stride_count;
    logic signed [63:0]      stride_sum;
    logic signed [31:0]      stride_min;
    logic signed [31:0]      stride_max;
    logic [CNT_W-1:0]        zero_strides;
    logic [CNT_W-1:0]        line_changes;
    logic [63:0]             trace_checksum;
  } out_item_t;

  // one classified beat between front and back
  typedef struct packed {
    op_t         op;
    logic        is_write;
    logic [63:0] address;
    logic [63:0] checksum;
  } q_entry_t;

endpackage

@@ rtl/asm_if.sv @@
// ----------------------------------------------------------------------------
// asm_if
// Valid/ready channels for access beats and result beats.
// ----------------------------------------------------------------------------
interface asm_in_if;
  import asm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface asm_out_if;
  import asm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/asm_front.sv @@
// ----------------------------------------------------------------------------
// asm_front
// Takes access beats, applies the capacity limit and keeps the checksum.
// ----------------------------------------------------------------------------
module asm_front (
  input  logic             clk,
  input  logic             rst,
  asm_in_if.sink           req,
  output asm_pkg::q_entry_t push_data,
  output logic             push_valid,
  input  logic             push_ready
);
  import asm_pkg::*;

  logic [ENTRY_W-1:0] entries;
  logic [ENTRY_W-1:0] entries_next;
  logic [63:0]        checksum;
  logic [63:0]        checksum_next;
  op_t                op;
  logic               take;

  assign req.ready  = push_ready;
  assign push_valid = req.valid;
  assign take       = req.valid && push_ready;

  always_comb begin
    entries_next  = entries;
    checksum_next = checksum;
    if (req.payload.kind == KIND_CLEAR) begin
      op            = OP_CLEAR;
      entries_next  = '0;
      checksum_next = '0;
    end else if (entries < ENTRY_W'(LOG_CAPACITY)) begin
      op            = OP_RECORD;
      entries_next  = entries + 1'b1;
      checksum_next = checksum + req.payload.address + {52'd0, req.payload.access_size}
                      + {63'd0, req.payload.is_write};
    end else begin
      op = OP_DROP;
    end
  end

  assign push_data.op       = op;
  assign push_data.is_write = req.payload.is_write;
  assign push_data.address  = req.payload.address;
  assign push_data.checksum = checksum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries  <= '0;
      checksum <= '0;
    end else if (take) begin
      entries  <= entries_next;
      checksum <= checksum_next;
    end
  end

endmodule

@@ rtl/asm_queue.sv @@
// ----------------------------------------------------------------------------
// asm_queue
// Short FIFO between the classifying front and the statistics back.
// ----------------------------------------------------------------------------
module asm_queue (
  input  logic              clk,
  input  logic              rst,
  input  asm_pkg::q_entry_t wr_data,
  input  logic              wr_valid,
  output logic              wr_ready,
  output asm_pkg::q_entry_t rd_data,
  output logic              rd_valid,
  input  logic              rd_ready
);
  import asm_pkg::*;

  q_entry_t        mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic            push;
  logic            pop;

  assign wr_ready = (count != Q_CW'(Q_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/asm_back.sv @@
// ----------------------------------------------------------------------------
// asm_back
// Per-type stride statistics and the registered result beat.
// ----------------------------------------------------------------------------
`include "access_stride_monitor_top_macros.svh"

module asm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [asm_pkg::SHIFT_W-1:0] line_shift,
  input  asm_pkg::q_entry_t           rd_data,
  input  logic                        rd_valid,
  output logic                        rd_ready,
  asm_out_if.source                   rsp
);
  import asm_pkg::*;

  logic [63:0]        last_addr [2];
  logic               have_last [2];
  logic [CNT_W-1:0]   cnt       [2];
  logic signed [63:0] sum       [2];
  logic signed [31:0] mn        [2];
  logic signed [31:0] mx        [2];
  logic [CNT_W-1:0]   zero_cnt  [2];
  logic [CNT_W-1:0]   chg_cnt   [2];

  logic               pop;
  logic               t;
  logic [63:0]        prev;
  logic signed [31:0] stride;
  logic               changed;
  logic               do_stride;
  logic [CNT_W-1:0]   cnt_next;
  logic signed [63:0] sum_next;
  logic signed [31:0] mn_next;
  logic signed [31:0] mx_next;
  logic [CNT_W-1:0]   zero_next;
  logic [CNT_W-1:0]   chg_next;
  out_item_t          res;

  assign rd_ready = !rsp.valid || rsp.ready;
  assign pop      = rd_valid && rd_ready;

  assign t         = rd_data.is_write;
  assign prev      = last_addr[t];
  assign stride    = rd_data.address[31:0] - prev[31:0];
  // line compare without shifting both sides
  assign changed   = (((rd_data.address ^ prev) >> line_shift) != 64'd0);
  assign do_stride = (rd_data.op == OP_RECORD) && have_last[t];

  always_comb begin
    cnt_next  = cnt[t];
    sum_next  = sum[t];
    mn_next   = mn[t];
    mx_next   = mx[t];
    zero_next = zero_cnt[t];
    chg_next  = chg_cnt[t];
    if (do_stride) begin
      cnt_next = (cnt[t] == CNT_MAX) ? cnt[t] : cnt[t] + 1'b1;
      sum_next = sum[t] + {{32{stride[31]}}, stride};
      if (stride < mn[t]) begin
        mn_next = stride;
      end
      if (stride > mx[t]) begin
        mx_next = stride;
      end
      if (stride == 32'sd0 && zero_cnt[t] != CNT_MAX) begin
        zero_next = zero_cnt[t] + 1'b1;
      end
      if (changed && chg_cnt[t] != CNT_MAX) begin
        chg_next = chg_cnt[t] + 1'b1;
      end
    end
  end

  always_comb begin
    res.accepted       = (rd_data.op == OP_RECORD);
    res.stride         = do_stride ? stride : 32'sd0;
    res.stride_valid   = do_stride;
    res.line_changed   = do_stride && changed;
    res.stride_count   = cnt_next;
    res.stride_sum     = sum_next;
    res.stride_min     = mn_next;
    res.stride_max     = mx_next;
    res.zero_strides   = zero_next;
    res.line_changes   = chg_next;
    res.trace_checksum = rd_data.checksum;
    if (rd_data.op == OP_CLEAR) begin
      res.stride_count = '0;
      res.stride_sum   = '0;
      res.stride_min   = STRIDE_MIN_RST;
      res.stride_max   = STRIDE_MAX_RST;
      res.zero_strides = '0;
      res.line_changes = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.payload <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (pop) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        last_addr[i] <= '0;
        have_last[i] <= 1'b0;
        cnt[i]       <= '0;
        sum[i]       <= '0;
        mn[i]        <= STRIDE_MIN_RST;
        mx[i]        <= STRIDE_MAX_RST;
        zero_cnt[i]  <= '0;
        chg_cnt[i]   <= '0;
      end
    end else if (pop) begin
      case (rd_data.op)
        OP_CLEAR: begin
          for (int i = 0; i < 2; i++) begin
            last_addr[i] <= '0;
            have_last[i] <= 1'b0;
            cnt[i]       <= '0;
            sum[i]       <= '0;
            mn[i]        <= STRIDE_MIN_RST;
            mx[i]        <= STRIDE_MAX_RST;
            zero_cnt[i]  <= '0;
            chg_cnt[i]   <= '0;
          end
        end
        OP_RECORD: begin
          last_addr[t] <= rd_data.address;
          have_last[t] <= 1'b1;
          cnt[t]       <= cnt_next;
          sum[t]       <= sum_next;
          mn[t]        <= mn_next;
          mx[t]        <= mx_next;
          zero_cnt[t]  <= zero_next;
          chg_cnt[t]   <= chg_next;
        end
        default: begin
        end
      endcase
    end
  end

  `ASM_ASSERT_NOW(a_stride_needs_accept, rsp.valid && rsp.payload.stride_valid, rsp.payload.accepted)
  `ASM_ASSERT_NOW(a_minmax_rd, cnt[0] != '0, mn[0] <= mx[0])
  `ASM_ASSERT_NOW(a_minmax_wr, cnt[1] != '0, mn[1] <= mx[1])
  `ASM_ASSERT_NEXT(a_clear_forgets, pop && rd_data.op == OP_CLEAR, !have_last[0] && !have_last[1])

endmodule

@@ rtl/access_stride_monitor_top.sv @@
// ----------------------------------------------------------------------------
// access_stride_monitor_top
// Read/write stride statistics and trace checksum over an access stream.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  req      in   kind, is_write, address, access_size
//  rsp      out  accepted, stride, stride_valid, line_changed, stats, checksum
//  cfg      in   cfg_we / cfg_wdata -> line_shift
//
// One beat per cycle sustained while rsp takes results. The front writes an accepted
// access beat into the 4-entry queue at its accepting edge. The back pops it once
// the result reg is free, registers the updated stats there and raises rsp.valid.
// The back's per-type update sets the rate.
// rst is synchronous; no clearing pass, req is ready the cycle after reset.
// A stalled rsp fills the queue; req.ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module access_stride_monitor_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [asm_pkg::SHIFT_W-1:0] cfg_wdata,
  asm_in_if.sink                      req,
  asm_out_if.source                   rsp
);
  import asm_pkg::*;

  logic [SHIFT_W-1:0] line_shift;
  q_entry_t           push_data;
  logic               push_valid;
  logic               push_ready;
  q_entry_t           rd_data;
  logic               rd_valid;
  logic               rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_shift <= LINE_SHIFT_RST;
    end else if (cfg_we) begin
      line_shift <= cfg_wdata;
    end
  end

  asm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  asm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (push_data),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready)
  );

  asm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .line_shift (line_shift),
    .rd_data    (rd_data),
    .rd_valid   (rd_valid),
    .rd_ready   (rd_ready),
    .rsp        (rsp)
  );

endmodule

@@ dv/access_stride_monitor_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// access_stride_monitor_top_tb
// Drives read/write access beats and clear beats into the stride monitor
// under random idling on both channels, predicts every result beat from its
// own model of the per-type stride statistics, and checks each result field
// by field. Covers several line shifts and clears.
// ----------------------------------------------------------------------------
module access_stride_monitor_top_tb;
  import asm_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [SHIFT_W-1:0] cfg_wdata;

  asm_in_if  req_if ();
  asm_out_if rsp_if ();

  access_stride_monitor_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // stimulus side
  in_item_t    access_q[$];
  out_item_t   stat_q[$];
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int          mismatches;
  logic [63:0] cursor[2];

  localparam logic [63:0] EXTREME_STEPS[4] = '{
    64'h0000_0000_8000_0000, 64'h0000_0000_7FFF_FFFF,
    64'hFFFF_FFFF_8000_0000, 64'h0000_0001_0000_0000
  };

  // model of the block
  logic [SHIFT_W-1:0] shift_cfg;
  int unsigned        taken;
  logic [63:0]        prev_addr[2];
  logic               have_prev[2];
  logic [CNT_W-1:0]   cnt_t[2];
  logic [63:0]        sum_t[2];
  logic signed [31:0] min_t[2];
  logic signed [31:0] max_t[2];
  logic [CNT_W-1:0]   zero_t[2];
  logic [CNT_W-1:0]   chg_t[2];
  logic [63:0]        csum;

  function automatic void clear_stats();
    taken = 0;
    csum  = '0;
    for (int t = 0; t < 2; t++) begin
      prev_addr[t] = '0;
      have_prev[t] = 1'b0;
      cnt_t[t]     = '0;
      sum_t[t]     = '0;
      min_t[t]     = STRIDE_MIN_RST;
      max_t[t]     = STRIDE_MAX_RST;
      zero_t[t]    = '0;
      chg_t[t]     = '0;
    end
  endfunction

  function automatic out_item_t predict_stats(in_item_t a);
    out_item_t          r;
    logic               t;
    logic [63:0]        prev;
    logic signed [31:0] s;
    r = '0;
    t = a.is_write;
    if (a.kind == KIND_CLEAR) begin
      clear_stats();
    end else if (taken < LOG_CAPACITY) begin
      r.accepted = 1'b1;
      taken++;
      csum += a.address + 64'(a.access_size) + 64'(t);
      if (have_prev[t]) begin
        prev = prev_addr[t];
        s = signed'(a.address[31:0] - prev[31:0]);
        r.stride       = s;
        r.stride_valid = 1'b1;
        r.line_changed = (a.address >> shift_cfg) != (prev >> shift_cfg);
        if (cnt_t[t] != CNT_MAX) cnt_t[t]++;
        sum_t[t] += {{32{s[31]}}, s};
        if (s < min_t[t]) min_t[t] = s;
        if (s > max_t[t]) max_t[t] = s;
        if (s == 0 && zero_t[t] != CNT_MAX) zero_t[t]++;
        if (r.line_changed && chg_t[t] != CNT_MAX) chg_t[t]++;
      end
      prev_addr[t] = a.address;
      have_prev[t] = 1'b1;
    end
    r.stride_count   = cnt_t[t];
    r.stride_sum     = sum_t[t];
    r.stride_min     = min_t[t];
    r.stride_max     = max_t[t];
    r.zero_strides   = zero_t[t];
    r.line_changes   = chg_t[t];
    r.trace_checksum = csum;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t mismatch on %s: expected %h, got %h", $realtime, name, exp_v, got_v);
    end
  endtask

  task automatic check_result(input out_item_t e, input out_item_t g);
    compare_field("accepted", 64'(e.accepted), 64'(g.accepted));
    compare_field("stride", 64'(e.stride), 64'(g.stride));
    compare_field("stride_valid", 64'(e.stride_valid), 64'(g.stride_valid));
    compare_field("line_changed", 64'(e.line_changed), 64'(g.line_changed));
    compare_field("stride_count", 64'(e.stride_count), 64'(g.stride_count));
    compare_field("stride_sum", e.stride_sum, g.stride_sum);
    compare_field("stride_min", 64'(e.stride_min), 64'(g.stride_min));
    compare_field("stride_max", 64'(e.stride_max), 64'(g.stride_max));
    compare_field("zero_strides", 64'(e.zero_strides), 64'(g.zero_strides));
    compare_field("line_changes", 64'(e.line_changes), 64'(g.line_changes));
    compare_field("trace_checksum", e.trace_checksum, g.trace_checksum);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver: predicts on every accepted access beat
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready)
        stat_q.insert(stat_q.size(), predict_stats(req_if.payload));
      if (!req_if.valid || req_if.ready) begin
        if (access_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          req_if.payload <= access_q.pop_front();
          req_if.valid   <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (stat_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%t result beat with nothing pending", $realtime);
        end else begin
          check_result(stat_q.pop_front(), rsp_if.payload);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic queue_access(input logic kind, input logic wr, input logic [63:0] addr,
                              input logic [11:0] size);
    in_item_t a;
    a.kind        = kind;
    a.is_write    = wr;
    a.address     = addr;
    a.access_size = size;
    while (access_q.size() >= 16) @(posedge clk);
    access_q.insert(access_q.size(), a);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (access_q.size() != 0 || req_if.valid || stat_q.size() != 0) @(negedge clk);
  endtask

  task automatic program_shift(input logic [SHIFT_W-1:0] v);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    shift_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_batch(input int n);
    logic        wr;
    logic [63:0] step;
    logic [31:0] r32;
    logic [11:0] sz;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        queue_access(KIND_CLEAR, 1'($urandom_range(1)), {$urandom, $urandom},
                     12'($urandom_range(4095)));
      end else if (pick < 8) begin
        queue_access(KIND_RECORD, 1'($urandom_range(1)), {$urandom, $urandom},
                     12'($urandom_range(4095)));
      end else begin
        wr = 1'($urandom_range(1));
        case ($urandom_range(7))
          0: step = '0;
          1: step = 64'($urandom_range(1, 16)) * 8;
          2: step = -(64'($urandom_range(1, 16)) * 8);
          3: step = 64'($urandom_range(1, 4)) << $urandom_range(16);
          4: begin
            r32  = $urandom;
            step = {{32{r32[31]}}, r32};
          end
          5: step = {$urandom, $urandom};
          6: step = EXTREME_STEPS[2'($urandom_range(3))];
          default: step = 64'd64;
        endcase
        cursor[wr] += step;
        case ($urandom_range(3))
          0: sz = 12'($urandom_range(4095));
          1: sz = 12'd1 << $urandom_range(6);
          2: sz = 12'hFFF;
          default: sz = 12'd8;
        endcase
        queue_access(KIND_RECORD, wr, cursor[wr], sz);
      end
    end
  endtask

  initial begin
    #60000000;
    $display("access_stride_monitor_top_tb failed");
    $finish;
  end

  initial begin
    logic [SHIFT_W-1:0] shifts[6];
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    mismatches     = 0;
    src_idle_pct   = 25;
    snk_idle_pct   = 80;
    shift_cfg      = LINE_SHIFT_RST;
    cursor[0]      = {$urandom, $urandom};
    cursor[1]      = {$urandom, $urandom};
    clear_stats();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed beats under the reset line shift
    queue_access(KIND_RECORD, 1'b0, 64'h1000, 12'd0);            // first read
    queue_access(KIND_RECORD, 1'b0, 64'h1000, 12'd4);            // zero stride
    queue_access(KIND_RECORD, 1'b0, 64'h1080, 12'd8);            // next line
    queue_access(KIND_RECORD, 1'b0, 64'h1040, 12'hFFF);          // negative stride
    queue_access(KIND_RECORD, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 12'hFFF);
    queue_access(KIND_RECORD, 1'b1, 64'h0, 12'd1);               // wraps to +1
    queue_access(KIND_RECORD, 1'b1, 64'h8000_0000, 12'd2);       // most negative
    queue_access(KIND_RECORD, 1'b1, 64'h1, 12'd2);
    queue_access(KIND_RECORD, 1'b1, 64'h8000_0000, 12'd4);       // most positive
    queue_access(KIND_RECORD, 1'b1, 64'h1_8000_0000, 12'd4);     // zero low, new line
    queue_access(KIND_RECORD, 1'b0, 64'h5555_5555_5555_5555, 12'h555);
    queue_access(KIND_RECORD, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 12'hAAA);
    queue_access(KIND_CLEAR, 1'b1, 64'h1234, 12'h10);
    queue_access(KIND_RECORD, 1'b1, 64'h40, 12'd8);
    queue_access(KIND_RECORD, 1'b1, 64'h40, 12'd8);
    queue_access(KIND_RECORD, 1'b0, 64'h0, 12'd0);
    queue_access(KIND_CLEAR, 1'b0, 64'h0, 12'd0);
    queue_access(KIND_RECORD, 1'b0, 64'hFFFF_FFFF_FFFF_FF80, 12'd64);

    shifts = '{6'd0, 6'd63, 6'd12, 6'd1, 6'($urandom_range(63)), LINE_SHIFT_RST};
    for (int p = 0; p < 6; p++) begin
      program_shift(shifts[p]);
      if (p == 2) begin
        src_idle_pct = 80;
        snk_idle_pct = 25;
      end else if (p == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      random_batch(315);
    end

    // clears back to back before a short run of both types
    program_shift(6'd3);
    queue_access(KIND_CLEAR, 1'b0, 64'h0, 12'd0);
    queue_access(KIND_CLEAR, 1'b1, {$urandom, $urandom}, 12'd0);
    for (int i = 0; i < 6; i++)
      queue_access(KIND_RECORD, i[0], {$urandom, $urandom}, 12'($urandom_range(4095)));

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("access_stride_monitor_top_tb passed");
    end else begin
      $display("access_stride_monitor_top_tb failed");
    end
    $finish;
  end

endmodule
